>>> sv/bmrs_pkg.sv
// ----------------------------------------------------------------------------
// bmrs_pkg
// shared constants, codes and controller/datapath interface types for the
// block mapped request splitter
// ----------------------------------------------------------------------------
package bmrs_pkg;

  localparam int BLOCK_SHIFT = 23;
  localparam longint BLOCK_BYTES = 64'd1 << BLOCK_SHIFT;
  localparam int MAP_ENTRIES = 1024;
  localparam int MAP_AW      = 10;

  localparam int OFFSET_W = 33;
  localparam int SIZE_W   = 29;
  localparam int LEN_W    = 24;
  localparam int INB_W    = BLOCK_SHIFT;
  localparam int BLK_W    = OFFSET_W - BLOCK_SHIFT + 1;
  localparam int ID_W     = 32;
  localparam int START_W  = 48;
  localparam int STRIDE_W = 32;
  localparam int ADDR_W   = 64;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_SEGS  = 64;
  localparam int SEG_CNT_W = 7;
  localparam longint SIZE_CAP = 63 * BLOCK_BYTES;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 32'd8388608;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SPLIT = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DATA_START   = 1'b0,
    REG_BLOCK_STRIDE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic mul;
    logic fill;
    logic adv;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

>>> sv/bmrs_ctrl.sv
// ----------------------------------------------------------------------------
// bmrs_ctrl
// sequencer: takes requests, steps each segment through map read, multiply,
// address add and output handshake
// ----------------------------------------------------------------------------
module bmrs_ctrl import bmrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_operation,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(in_operation) == OP_SPLIT) begin
            cmd.start = 1'b1;
            state_nxt = S_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.fill  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.adv   = 1'b1;
          state_nxt = status.last ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bmrs_datapath.sv
// ----------------------------------------------------------------------------
// bmrs_datapath
// block map memory, config registers, segment counters, address multiply/add
// and output registers
// ----------------------------------------------------------------------------
module bmrs_datapath import bmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [MAP_AW-1:0]    in_map_index,
  input  logic [ID_W-1:0]      in_device_block,
  input  logic [OFFSET_W-1:0]  in_req_offset,
  input  logic [SIZE_W-1:0]    in_req_size,
  output logic [ID_W-1:0]      out_seg_block,
  output logic [ADDR_W-1:0]    out_dev_address,
  output logic [SIZE_W-1:0]    out_buffer_offset,
  output logic [LEN_W-1:0]     out_seg_length,
  output logic                 out_out_of_map,
  output logic                 out_last
);

  logic [ID_W-1:0]      map_mem [MAP_ENTRIES];
  logic [ID_W-1:0]      rdata_r;
  logic [START_W-1:0]   data_start_r;
  logic [STRIDE_W-1:0]  block_stride_r;
  logic [BLK_W-1:0]     blk_r;
  logic [INB_W-1:0]     inb_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SIZE_W-1:0]    done_r;
  logic [SEG_CNT_W-1:0] nseg_r;
  logic [ADDR_W-1:0]    prod_r;

  logic [ID_W-1:0]      seg_block_r;
  logic [ADDR_W-1:0]    dev_addr_r;
  logic [SIZE_W-1:0]    buf_off_r;
  logic [LEN_W-1:0]     seg_len_r;
  logic                 oom_r;
  logic                 last_r;

  logic [LEN_W-1:0]     avail;
  logic [SIZE_W-1:0]    remain;
  logic [LEN_W-1:0]     seg_len;
  logic                 oom;
  logic                 fin;
  logic [SEG_CNT_W-1:0] nseg_inc;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r   <= '0;
      block_stride_r <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DATA_START:   data_start_r   <= cfg_data[START_W-1:0];
        REG_BLOCK_STRIDE: block_stride_r <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // block map
  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, in_map_index} < (MAP_AW+1)'(MAP_ENTRIES))) begin
      map_mem[in_map_index] <= in_device_block;
    end
    if (cmd.rd) begin
      rdata_r <= map_mem[blk_r[MAP_AW-1:0]];
    end
  end

  // segment length and end of request
  assign avail    = LEN_W'(BLOCK_BYTES) - {1'b0, inb_r};
  assign remain   = size_r - done_r;
  assign seg_len  = (remain < SIZE_W'(avail)) ? LEN_W'(remain) : avail;
  assign oom      = (blk_r >= BLK_W'(MAP_ENTRIES));
  assign nseg_inc = nseg_r + SEG_CNT_W'(1);
  assign fin      = ((done_r + SIZE_W'(seg_len)) >= size_r) ||
                    (nseg_inc >= SEG_CNT_W'(MAX_SEGS));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      blk_r  <= BLK_W'(in_req_offset >> BLOCK_SHIFT);
      inb_r  <= in_req_offset[INB_W-1:0];
      size_r <= (in_req_size > SIZE_W'(SIZE_CAP)) ? SIZE_W'(SIZE_CAP) : in_req_size;
      done_r <= '0;
      nseg_r <= '0;
    end else if (cmd.adv) begin
      blk_r  <= blk_r + BLK_W'(1);
      inb_r  <= '0;
      done_r <= done_r + SIZE_W'(seg_len_r);
      nseg_r <= nseg_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= ADDR_W'(block_stride_r) * ADDR_W'(rdata_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      seg_block_r <= oom ? '0 : rdata_r;
      dev_addr_r  <= oom ? '0 : (ADDR_W'(data_start_r) + prod_r + ADDR_W'(inb_r));
      buf_off_r   <= done_r;
      seg_len_r   <= seg_len;
      oom_r       <= oom;
      last_r      <= fin;
    end
  end

  assign status.last       = last_r;
  assign out_seg_block     = seg_block_r;
  assign out_dev_address   = dev_addr_r;
  assign out_buffer_offset = buf_off_r;
  assign out_seg_length    = seg_len_r;
  assign out_out_of_map    = oom_r;
  assign out_last          = last_r;

endmodule

>>> sv/block_mapped_request_splitter.sv
// ----------------------------------------------------------------------------
// block_mapped_request_splitter
// splits a file byte request into per-block device segments
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): in_operation 0 loads one map entry
// (in_map_index -> in_device_block), 1 splits a request given by
// in_req_offset and in_req_size. a map load gives no segment. a split
// request gives one segment per file block it touches, up to 64, on the
// out_ channel (out_valid/out_ready), out_last on the final one. each
// segment goes through map memory read, stride multiply and address add,
// then the output register holds it until out_ready. a new request is
// taken only after the last segment of the previous one is taken.
// cfg_we/cfg_index/cfg_data write data_start (0) and block_stride (1); write
// them only while the block is idle. reset returns the sequencer to idle and
// the config registers to their defaults; the block map is not cleared and
// must be loaded before use. a stalled receiver holds the current segment.
// ----------------------------------------------------------------------------
module block_mapped_request_splitter import bmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [MAP_AW-1:0]    in_map_index,
  input  logic [ID_W-1:0]      in_device_block,
  input  logic [OFFSET_W-1:0]  in_req_offset,
  input  logic [SIZE_W-1:0]    in_req_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      out_seg_block,
  output logic [ADDR_W-1:0]    out_dev_address,
  output logic [SIZE_W-1:0]    out_buffer_offset,
  output logic [LEN_W-1:0]     out_seg_length,
  output logic                 out_out_of_map,
  output logic                 out_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bmrs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  bmrs_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_map_index      (in_map_index),
    .in_device_block   (in_device_block),
    .in_req_offset     (in_req_offset),
    .in_req_size       (in_req_size),
    .out_seg_block     (out_seg_block),
    .out_dev_address   (out_dev_address),
    .out_buffer_offset (out_buffer_offset),
    .out_seg_length    (out_seg_length),
    .out_out_of_map    (out_out_of_map),
    .out_last          (out_last)
  );

endmodule

>>> sim/bmrs_segment_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bmrs_segment_checker
// Watches the request and segment channels of the splitter. It keeps its own
// copy of the block map and the layout registers. For every accepted split
// request it computes the segment list, and it checks each accepted segment
// against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module bmrs_segment_checker import bmrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_operation,
  input  logic [MAP_AW-1:0]    in_map_index,
  input  logic [ID_W-1:0]      in_device_block,
  input  logic [OFFSET_W-1:0]  in_req_offset,
  input  logic [SIZE_W-1:0]    in_req_size,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ID_W-1:0]      out_seg_block,
  input  logic [ADDR_W-1:0]    out_dev_address,
  input  logic [SIZE_W-1:0]    out_buffer_offset,
  input  logic [LEN_W-1:0]     out_seg_length,
  input  logic                 out_out_of_map,
  input  logic                 out_last,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [ID_W-1:0]   block;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] buf_off;
    logic [LEN_W-1:0]  len;
    logic              oom;
    logic              last;
  } segment_t;

  logic [ID_W-1:0]     map_model [MAP_ENTRIES];
  logic [START_W-1:0]  data_start;
  logic [STRIDE_W-1:0] block_stride;
  segment_t            expected_segments [$];
  int                  mismatches = 0;

  task automatic expand_request(input logic [OFFSET_W-1:0] offset,
                                input logic [SIZE_W-1:0] size);
    longint            blk, inb, total, done, span;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    segment_t          seg;
    int                n;
    total = (size > SIZE_CAP) ? SIZE_CAP : longint'(size);
    blk = offset >> BLOCK_SHIFT;
    inb = offset[INB_W-1:0];
    done = 0;
    n = 0;
    forever begin
      span = BLOCK_BYTES - inb;
      if (span > total - done) span = total - done;
      seg.oom = (blk >= MAP_ENTRIES);
      id = '0;
      addr = '0;
      if (!seg.oom) begin
        id = map_model[blk];
        addr = ADDR_W'(data_start) + ADDR_W'(block_stride) * ADDR_W'(id) + ADDR_W'(inb);
      end
      seg.block = id;
      seg.addr = addr;
      seg.buf_off = done[SIZE_W-1:0];
      seg.len = span[LEN_W-1:0];
      done += span;
      inb = 0;
      blk++;
      n++;
      seg.last = (done >= total) || (n >= MAX_SEGS);
      expected_segments.push_back(seg);
      if (seg.last) break;
    end
  endtask

  task automatic check_segment();
    segment_t want;
    if (expected_segments.size() == 0) begin
      $display("%0t: unexpected segment block %h address %h offset %h length %h oom %b last %b",
               $time, out_seg_block, out_dev_address, out_buffer_offset, out_seg_length,
               out_out_of_map, out_last);
      mismatches++;
    end else begin
      want = expected_segments.pop_front();
      if (out_seg_block !== want.block) begin
        $display("%0t: seg_block expected %h actual %h", $time, want.block, out_seg_block);
        mismatches++;
      end
      if (out_dev_address !== want.addr) begin
        $display("%0t: dev_address expected %h actual %h", $time, want.addr, out_dev_address);
        mismatches++;
      end
      if (out_buffer_offset !== want.buf_off) begin
        $display("%0t: buffer_offset expected %h actual %h", $time, want.buf_off,
                 out_buffer_offset);
        mismatches++;
      end
      if (out_seg_length !== want.len) begin
        $display("%0t: seg_length expected %h actual %h", $time, want.len, out_seg_length);
        mismatches++;
      end
      if (out_out_of_map !== want.oom) begin
        $display("%0t: out_of_map expected %b actual %b", $time, want.oom, out_out_of_map);
        mismatches++;
      end
      if (out_last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, out_last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      data_start = '0;
      block_stride = STRIDE_RESET;
      expected_segments.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DATA_START:   data_start = cfg_data[START_W-1:0];
          REG_BLOCK_STRIDE: block_stride = cfg_data[STRIDE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_operation == OP_LOAD) map_model[in_map_index] = in_device_block;
        else expand_request(in_req_offset, in_req_size);
      end
      if (out_valid && out_ready) check_segment();
    end
    fail_count <= mismatches;
    pending <= expected_segments.size();
  end

endmodule

>>> sim/tb_block_mapped_request_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_mapped_request_splitter
// Drives map loads and split requests into the splitter under random
// handshake gaps and output stalls. It moves through several layouts of
// data_start and block_stride, the extreme values among them. Every map
// entry that a split touches is loaded first. The checker does all the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_block_mapped_request_splitter;
  import bmrs_pkg::*;

  localparam int RUN_LIMIT    = 3000000;
  localparam int DRAIN_CYCLES = 20;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = 1'b0;
  logic [MAP_AW-1:0]    in_map_index = '0;
  logic [ID_W-1:0]      in_device_block = '0;
  logic [OFFSET_W-1:0]  in_req_offset = '0;
  logic [SIZE_W-1:0]    in_req_size = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ID_W-1:0]      out_seg_block;
  logic [ADDR_W-1:0]    out_dev_address;
  logic [SIZE_W-1:0]    out_buffer_offset;
  logic [LEN_W-1:0]     out_seg_length;
  logic                 out_out_of_map;
  logic                 out_last;
  int                   fail_count;
  int                   pending;

  bit                   mapped [MAP_ENTRIES];
  bit                   tx_gaps = 1'b1;
  bit                   rx_stalls = 1'b1;
  int                   sent = 0;
  int                   cycle_count = 0;

  block_mapped_request_splitter i_dut (.*);
  bmrs_segment_checker i_checker (.*);

  always #10 clk = ~clk;

  task automatic send_request(input op_t op, input logic [MAP_AW-1:0] idx,
                              input logic [ID_W-1:0] id, input logic [OFFSET_W-1:0] off,
                              input logic [SIZE_W-1:0] size);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_map_index <= idx;
    in_device_block <= id;
    in_req_offset <= off;
    in_req_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic load_entry(input logic [MAP_AW-1:0] idx, input logic [ID_W-1:0] id);
    send_request(OP_LOAD, idx, id, OFFSET_W'({$urandom, $urandom}), SIZE_W'($urandom));
    mapped[idx] = 1'b1;
  endtask

  // loads every in-map block the request will touch that is not yet mapped, then sends it
  task automatic split_file_range(input logic [OFFSET_W-1:0] off,
                                  input logic [SIZE_W-1:0] size);
    longint first, final_blk, capped;
    capped = (size > SIZE_CAP) ? SIZE_CAP : longint'(size);
    first = off >> BLOCK_SHIFT;
    final_blk = (capped == 0) ? first : (longint'(off) + capped - 1) >> BLOCK_SHIFT;
    if (final_blk > first + MAX_SEGS - 1) final_blk = first + MAX_SEGS - 1;
    for (longint b = first; b <= final_blk && b < MAP_ENTRIES; b++)
      if (!mapped[b]) load_entry(MAP_AW'(b), $urandom);
    send_request(OP_SPLIT, MAP_AW'($urandom), $urandom, off, size);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_layout(input logic [START_W-1:0] start,
                                input logic [STRIDE_W-1:0] stride);
    cfg_we <= 1'b1;
    cfg_index <= REG_DATA_START;
    cfg_data <= start;
    @(posedge clk);
    cfg_index <= REG_BLOCK_STRIDE;
    cfg_data <= {16'($urandom), stride};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stall;
    forever begin
      stall = rx_stalls ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("block_mapped_request_splitter verification failed");
      $finish;
    end
  end

  initial begin
    logic [START_W-1:0]  start_tbl [6];
    logic [STRIDE_W-1:0] stride_tbl [6];
    logic [SIZE_W-1:0]   size;
    longint              blk, inb;
    int                  pick, base;
    bit                  paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero size, block crossings, end of map, oversize
    load_entry(0, 32'h0000_0000);
    load_entry(1, 32'hFFFF_FFFF);
    load_entry(2, 32'h8000_0000);
    load_entry(MAP_ENTRIES - 1, 32'hFFFF_FFFF);
    split_file_range(0, 0);
    split_file_range(0, 1);
    split_file_range(0, SIZE_W'(BLOCK_BYTES));
    split_file_range(OFFSET_W'(BLOCK_BYTES - 1), 2);
    split_file_range(5, SIZE_W'(BLOCK_BYTES));
    split_file_range(OFFSET_W'(BLOCK_BYTES), SIZE_W'(2 * BLOCK_BYTES));
    split_file_range('1, 0);
    split_file_range('1, '1);
    split_file_range(OFFSET_W'((MAP_ENTRIES - 1) * BLOCK_BYTES), SIZE_W'(SIZE_CAP));
    split_file_range(OFFSET_W'((MAP_ENTRIES - 2) * BLOCK_BYTES + 7), SIZE_W'(SIZE_CAP + 1));

    start_tbl[0] = '0;                          stride_tbl[0] = '0;
    start_tbl[1] = '1;                          stride_tbl[1] = '1;
    start_tbl[2] = START_W'({$urandom, $urandom}); stride_tbl[2] = $urandom;
    start_tbl[3] = START_W'({$urandom, $urandom}); stride_tbl[3] = 1;
    start_tbl[4] = '1;                          stride_tbl[4] = STRIDE_RESET;
    start_tbl[5] = START_W'($urandom);          stride_tbl[5] = $urandom;

    base = sent;
    for (int p = 0; p < 6; p++) begin
      settle();
      program_layout(start_tbl[p], stride_tbl[p]);
      tx_gaps = (p != 2 && p != 4);
      rx_stalls = (p != 1 && p != 2);
      while (sent < base + (p + 1) * 52) begin
        if (p == 3 && !paused && sent >= base + 3 * 52 + 26) begin
          settle();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          load_entry(MAP_AW'($urandom), $urandom);
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 5) blk = $urandom_range(0, 31);
          else if (pick < 8) blk = $urandom_range(0, MAP_ENTRIES - 1);
          else blk = $urandom_range(MAP_ENTRIES - 24, MAP_ENTRIES - 1);
          pick = $urandom_range(0, 3);
          if (pick == 0) inb = 0;
          else if (pick == 1) inb = BLOCK_BYTES - 1;
          else inb = $urandom_range(0, 32'(BLOCK_BYTES - 1));
          pick = $urandom_range(0, 19);
          if (pick < 2) size = 0;
          else if (pick < 8) size = SIZE_W'($urandom_range(1, 32'(BLOCK_BYTES)));
          else if (pick < 14)
            size = SIZE_W'($urandom_range(32'(BLOCK_BYTES), 32'(4 * BLOCK_BYTES)));
          else if (pick < 16) size = SIZE_W'($urandom_range(1, 8) * BLOCK_BYTES);
          else if (pick == 16)
            size = SIZE_W'($urandom_range(32'(4 * BLOCK_BYTES), 32'(SIZE_CAP)));
          else if (pick == 17)
            size = SIZE_W'($urandom_range(32'(SIZE_CAP), 32'((1 << SIZE_W) - 1)));
          else if (pick == 18) size = SIZE_W'($urandom);
          else size = SIZE_W'($urandom_range(1, 511));
          split_file_range(OFFSET_W'(blk * BLOCK_BYTES + inb), size);
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("block_mapped_request_splitter verification clean");
    end else begin
      $display("block_mapped_request_splitter verification failed");
    end
    $finish;
  end

endmodule
